// ----- rtl/dbas_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package dbas_pkg;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_DRAW_CALC,
      ST_DRAW_UPD,
      ST_READ_OUT
   } state_type;

   // request function codes
   localparam logic [1:0] FUNC_DRAW  = 2'd0;
   localparam logic [1:0] FUNC_READ  = 2'd1;
   localparam logic [1:0] FUNC_CLEAR = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_FRAME_HEIGHT = 2'd1;

   // configuration reset values
   localparam logic [8:0] FRAME_WIDTH_RESET  = 9'd80;
   localparam logic [7:0] FRAME_HEIGHT_RESET = 8'd40;

   // output characters
   localparam logic [6:0] CHAR_NEWLINE = 7'd10;
   localparam logic [6:0] CHAR_SPACE   = 7'd32;

   // brightness ramp, dense to sparse; first character sits in the top byte
   localparam int RAMP_LEN = 70;
   localparam logic [RAMP_LEN*8-1:0] RAMP_TEXT =
      "$@B%8&WM#*oahkbdpqwmZO0QLCJUYXzcvunxrjft/\\|()1{}[]?-_+~<>i!lI;:,\"^`'. ";

   // look up one ramp entry; entries past the ramp give a space
   function automatic logic [6:0] ramp_char(input logic [6:0] c);
      logic [9:0] sh;
      sh = 10'((RAMP_LEN - 1 - int'(c)) * 8);
      if (int'(c) >= RAMP_LEN) begin
         return CHAR_SPACE;
      end
      return RAMP_TEXT[sh +: 7];
   endfunction

endpackage

`default_nettype wire

// ----- rtl/depth_buffer_ascii_shader.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Character-cell depth buffer with an ASCII brightness ramp.
// Request channel: start/busy with req_func, req_x_coord, req_y_coord,
// req_depth; a request is taken at an edge with start high and busy low.
// Draw (func 0) keeps the nearest non-zero depth of the cell hit by the point.
// Read (func 1) returns the next cell in row-major order as one character
// on rsp_char_code with rsp_end_of_frame, marked by a one-cycle rsp_valid.
// Clear (func 2) zeroes every cell; func 3 is taken and ignored.
// Timing: a read gives its response in the cycle after acceptance, and the
// next request may be taken once the response is out. A draw passes
// through index calculation with memory read, then write-back.
// Both follow from the registered read of the depth memory.
// A clear, and the pass after reset, sweeps the memory one cell a cycle:
// all MAX_WIDTH*MAX_HEIGHT cells, with busy high. Configuration writes on the
// csr_ channel are always taken (csr_ready stays high).
// Reset clears the read position and loads width 80 and height 40.
// The receiver cannot stall; rsp_valid is a strobe only.
module depth_buffer_ascii_shader #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 128,
   parameter int RAMP_LAST  = 69
) (
   input  wire logic                clock,
   input  wire logic                reset,
   // request channel
   input  wire logic                start,
   output logic                     busy,
   input  wire logic [1:0]          req_func,
   input  wire logic signed [15:0]  req_x_coord,
   input  wire logic signed [15:0]  req_y_coord,
   input  wire logic [15:0]         req_depth,
   // response channel
   output logic                     rsp_valid,
   output logic [6:0]               rsp_char_code,
   output logic                     rsp_end_of_frame,
   // configuration channel
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [1:0]          csr_index,
   input  wire logic [8:0]          csr_wdata
);

   localparam int CELLS  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int W_W    = $clog2(MAX_WIDTH + 1);
   localparam int H_W    = $clog2(MAX_HEIGHT + 1);
   localparam int TOT_W  = W_W + H_W;
   localparam int IDX_SW = (TOT_W + 2 > 18) ? TOT_W + 2 : 18;
   localparam logic [6:0] RAMP_K = 7'(RAMP_LAST);

   // state
   dbas_pkg::state_type state_ff, state_in;

   logic [8:0]         frame_width_ff, frame_width_in;
   logic [7:0]         frame_height_ff, frame_height_in;
   logic [ADDR_W-1:0]  clr_ff, clr_in;
   logic [ADDR_W-1:0]  read_pointer_ff, read_pointer_in;
   logic [W_W-1:0]     read_column_ff, read_column_in;
   logic [ADDR_W-1:0]  idx_ff, idx_in;
   logic               hit_ff, hit_in;
   logic signed [15:0] x_ff, x_in;
   logic signed [15:0] y_ff, y_in;
   logic [15:0]        depth_ff, depth_in;

   // depth memory
   logic [15:0]        mem [CELLS];
   logic [15:0]        rdata_ff;
   logic [ADDR_W-1:0]  mem_raddr;
   logic [ADDR_W-1:0]  mem_waddr;
   logic [15:0]        mem_wdata;
   logic               mem_we;

   // frame geometry
   logic [W_W-1:0]     w_eff;
   logic [H_W-1:0]     h_eff;
   logic [TOT_W-1:0]   total;

   // draw address math
   logic signed [IDX_SW-1:0] xs, ys, ws, hs, row_s, idx_s;
   logic                     drop;

   // read path
   logic               stale;
   logic [ADDR_W-1:0]  ptr_adj;
   logic [W_W-1:0]     col_adj;
   logic [22:0]        prod;
   logic [6:0]         ramp_idx;
   logic               last_col;
   logic               last_cell;

   // saturate width and height
   always_comb begin
      if (frame_width_ff == '0) begin
         w_eff = W_W'(1);
      end else if (int'(frame_width_ff) > MAX_WIDTH) begin
         w_eff = W_W'(MAX_WIDTH);
      end else begin
         w_eff = W_W'(frame_width_ff);
      end
      if (frame_height_ff == '0) begin
         h_eff = H_W'(1);
      end else if (int'(frame_height_ff) > MAX_HEIGHT) begin
         h_eff = H_W'(MAX_HEIGHT);
      end else begin
         h_eff = H_W'(frame_height_ff);
      end
      total = TOT_W'(w_eff) * TOT_W'(h_eff);
   end

   // map a point to a cell index
   always_comb begin
      xs    = IDX_SW'(x_ff);
      ys    = IDX_SW'(y_ff);
      ws    = $signed(IDX_SW'(w_eff));
      hs    = $signed(IDX_SW'(h_eff));
      drop  = (2 * xs < -ws) || (2 * xs > ws) || (ys < -hs) || (ys > hs);
      row_s = (hs - ys) >>> 1;
      idx_s = row_s * ws + (ws >>> 1) + xs;
   end

   // restart the read position when it lies outside the frame
   always_comb begin
      stale   = (TOT_W'(read_pointer_ff) >= total) || (read_column_ff >= w_eff);
      ptr_adj = stale ? '0 : read_pointer_ff;
      col_adj = stale ? '0 : read_column_ff;
   end

   // shade the fetched cell
   always_comb begin
      prod      = {7'b0, rdata_ff} * {16'b0, RAMP_K};
      ramp_idx  = prod[22:16];
      last_col  = (read_column_ff == w_eff - W_W'(1));
      last_cell = (TOT_W'(read_pointer_ff) == total - TOT_W'(1));
   end

   // controller: next state, memory controls and register updates
   always_comb begin
      state_in        = state_ff;
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      clr_in          = clr_ff;
      read_pointer_in = read_pointer_ff;
      read_column_in  = read_column_ff;
      idx_in          = idx_ff;
      hit_in          = hit_ff;
      x_in            = x_ff;
      y_in            = y_ff;
      depth_in        = depth_ff;
      mem_raddr       = ptr_adj;
      mem_waddr       = idx_ff;
      mem_wdata       = depth_ff;
      mem_we          = 1'b0;
      busy            = (state_ff != dbas_pkg::ST_IDLE);
      csr_ready       = 1'b1;
      rsp_valid       = 1'b0;
      rsp_char_code   = dbas_pkg::CHAR_SPACE;
      rsp_end_of_frame = 1'b0;

      // take configuration writes
      if (csr_valid) begin
         case (csr_index)
            dbas_pkg::CSR_FRAME_WIDTH:  frame_width_in  = csr_wdata;
            dbas_pkg::CSR_FRAME_HEIGHT: frame_height_in = csr_wdata[7:0];
            default: ;
         endcase
      end

      case (state_ff)
         dbas_pkg::ST_IDLE: begin
            // fetch for a read is issued here, at the adjusted position
            if (start) begin
               case (req_func)
                  dbas_pkg::FUNC_DRAW: begin
                     x_in     = req_x_coord;
                     y_in     = req_y_coord;
                     depth_in = req_depth;
                     state_in = dbas_pkg::ST_DRAW_CALC;
                  end
                  dbas_pkg::FUNC_READ: begin
                     read_pointer_in = ptr_adj;
                     read_column_in  = col_adj;
                     state_in        = dbas_pkg::ST_READ_OUT;
                  end
                  dbas_pkg::FUNC_CLEAR: begin
                     clr_in   = '0;
                     state_in = dbas_pkg::ST_CLEAR;
                  end
                  default: ;
               endcase
            end
         end

         dbas_pkg::ST_CLEAR: begin
            // sweep the store with zeros
            mem_waddr = clr_ff;
            mem_wdata = '0;
            mem_we    = 1'b1;
            clr_in    = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(CELLS - 1)) begin
               state_in = dbas_pkg::ST_IDLE;
            end
         end

         dbas_pkg::ST_DRAW_CALC: begin
            // read the target cell
            mem_raddr = idx_s[ADDR_W-1:0];
            idx_in    = idx_s[ADDR_W-1:0];
            hit_in    = !drop && (idx_s >= 0) &&
                        (idx_s < $signed(IDX_SW'(total)));
            state_in  = dbas_pkg::ST_DRAW_UPD;
         end

         dbas_pkg::ST_DRAW_UPD: begin
            // keep the nearest non-zero depth
            mem_we   = hit_ff && ((rdata_ff == '0) || (rdata_ff > depth_ff));
            state_in = dbas_pkg::ST_IDLE;
         end

         dbas_pkg::ST_READ_OUT: begin
            rsp_valid        = 1'b1;
            rsp_end_of_frame = last_cell;
            if (last_col) begin
               rsp_char_code = dbas_pkg::CHAR_NEWLINE;
            end else if ((ramp_idx == '0) || (ramp_idx >= RAMP_K)) begin
               rsp_char_code = dbas_pkg::CHAR_SPACE;
            end else begin
               rsp_char_code = dbas_pkg::ramp_char(ramp_idx);
            end
            // advance the read position
            if (last_cell) begin
               read_pointer_in = '0;
               read_column_in  = '0;
            end else begin
               read_pointer_in = read_pointer_ff + ADDR_W'(1);
               read_column_in  = last_col ? '0 : read_column_ff + W_W'(1);
            end
            state_in = dbas_pkg::ST_IDLE;
         end

         default: begin
            state_in = dbas_pkg::ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dbas_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= dbas_pkg::FRAME_WIDTH_RESET;
         frame_height_ff <= dbas_pkg::FRAME_HEIGHT_RESET;
         clr_ff          <= '0;
         read_pointer_ff <= '0;
         read_column_ff  <= '0;
         hit_ff          <= 1'b0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         clr_ff          <= clr_in;
         read_pointer_ff <= read_pointer_in;
         read_column_ff  <= read_column_in;
         hit_ff          <= hit_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      depth_ff <= depth_in;
   end

   // depth memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_raddr];
   end

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

   localparam int CELL_COUNT     = 256 * 128;
   localparam int RAMP_STEPS     = 69;
   localparam int WATCHDOG_LIMIT = 150000;
   localparam int REPORT_LIMIT   = 10;

   // codes the package leaves unnamed
   localparam logic [1:0] FUNC_SPARE = 2'd3;
   localparam logic [1:0] CSR_SPARE  = 2'd3;

   // expected character stream of the frame buffer
   class frame_scoreboard;
      typedef struct packed {
         logic [6:0] char_code;
         logic       end_of_frame;
      } cell_t;

      logic [15:0] depth_cells [CELL_COUNT];
      int unsigned read_index;
      int unsigned read_col;
      logic [8:0]  width_reg;
      logic [7:0]  height_reg;
      cell_t       expected_cells [$];
      int          failures;
      string       ramp = {"$@B%8&WM#*oahkbdpqwmZO0QLCJUYXzcvunxrjft",
                           "/\\|()1{}[]?-_+~<>i!lI;:,\"^\140'. "};

      function new();
         foreach (depth_cells[i]) depth_cells[i] = '0;
         read_index = 0;
         read_col   = 0;
         width_reg  = dbas_pkg::FRAME_WIDTH_RESET;
         height_reg = dbas_pkg::FRAME_HEIGHT_RESET;
         failures   = 0;
      endfunction

      // saturate the frame size to what the store holds
      function int eff_width();
         if (width_reg < 1) return 1;
         if (width_reg > 256) return 256;
         return int'(width_reg);
      endfunction

      function int eff_height();
         if (height_reg < 1) return 1;
         if (height_reg > 128) return 128;
         return int'(height_reg);
      endfunction

      function void set_register(input logic [1:0] idx, input logic [8:0] data);
         if (idx == dbas_pkg::CSR_FRAME_WIDTH) begin
            width_reg = data;
         end else if (idx == dbas_pkg::CSR_FRAME_HEIGHT) begin
            height_reg = data[7:0];
         end
      endfunction

      // keep the nearest non-zero depth of the cell hit by the point
      function void draw_point(input int x, input int y, input logic [15:0] z);
         int w;
         int h;
         int row;
         int idx;
         w = eff_width();
         h = eff_height();
         if (2 * x < -w || 2 * x > w) return;
         if (y < -h || y > h) return;
         row = (h - y) / 2;
         idx = row * w + w / 2 + x;
         if (idx < 0 || idx >= w * h) return;
         if (depth_cells[idx] == 0 || depth_cells[idx] > z) depth_cells[idx] = z;
      endfunction

      // produce the next cell in row-major order and advance the position
      function void predict_read();
         int unsigned w;
         int unsigned total;
         int unsigned c;
         cell_t       slot;
         w     = eff_width();
         total = w * eff_height();
         if (read_index >= total || read_col >= w) begin
            read_index = 0;
            read_col   = 0;
         end
         if (read_col == w - 1) begin
            slot.char_code = dbas_pkg::CHAR_NEWLINE;
         end else begin
            c = (int'(depth_cells[read_index]) * RAMP_STEPS) >> 16;
            if (c == 0 || c >= RAMP_STEPS) slot.char_code = dbas_pkg::CHAR_SPACE;
            else slot.char_code = 7'(ramp[c]);
         end
         slot.end_of_frame = (read_index == total - 1);
         expected_cells.push_back(slot);
         if (slot.end_of_frame) begin
            read_index = 0;
            read_col   = 0;
         end else begin
            read_index++;
            read_col = (read_col == w - 1) ? 0 : read_col + 1;
         end
      endfunction

      function void note_request(input logic [1:0] func, input logic signed [15:0] x,
                                 input logic signed [15:0] y, input logic [15:0] z);
         case (func)
            dbas_pkg::FUNC_DRAW: begin
               draw_point(int'(x), int'(y), z);
            end
            dbas_pkg::FUNC_READ: begin
               predict_read();
            end
            dbas_pkg::FUNC_CLEAR: begin
               foreach (depth_cells[i]) depth_cells[i] = '0;
            end
            default: begin
            end
         endcase
      endfunction

      function void check_cell(input logic [6:0] code, input logic eof);
         cell_t want;
         if (expected_cells.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("unexpected cell: char %0d end_of_frame %0b", code, eof);
            return;
         end
         want = expected_cells.pop_front();
         if (want.char_code !== code || want.end_of_frame !== eof) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("cell mismatch: expected char %0d eof %0b, got char %0d eof %0b",
                        want.char_code, want.end_of_frame, code, eof);
         end
      endfunction

      function int pending();
         return expected_cells.size();
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic [1:0]         req_func = dbas_pkg::FUNC_DRAW;
   logic signed [15:0] req_x_coord = '0;
   logic signed [15:0] req_y_coord = '0;
   logic [15:0]        req_depth = '0;
   logic               csr_valid = 1'b0;
   logic [1:0]         csr_index = dbas_pkg::CSR_FRAME_WIDTH;
   logic [8:0]         csr_wdata = '0;
   wire logic          busy;
   wire logic          rsp_valid;
   wire logic [6:0]    rsp_char_code;
   wire logic          rsp_end_of_frame;
   wire logic          csr_ready;

   frame_scoreboard    sb;
   int                 idle_pct = 28;
   int                 stall_cycles = 0;

   depth_buffer_ascii_shader i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_func         (req_func),
      .req_x_coord      (req_x_coord),
      .req_y_coord      (req_y_coord),
      .req_depth        (req_depth),
      .rsp_valid        (rsp_valid),
      .rsp_char_code    (rsp_char_code),
      .rsp_end_of_frame (rsp_end_of_frame),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #10 clock = ~clock;

   // check every response strobe against the oldest expected cell
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) sb.check_cell(rsp_char_code, rsp_end_of_frame);
   end

   // abort when nothing has moved for too long
   always @(posedge clock) begin
      if ((start && busy === 1'b0) || rsp_valid === 1'b1 ||
          (csr_valid && csr_ready === 1'b1)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("depth_buffer_ascii_shader test failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // hold one request until taken, then idle at random
   task automatic send_request(input logic [1:0] func, input logic [15:0] x,
                               input logic [15:0] y, input logic [15:0] z);
      start       <= 1'b1;
      req_func    <= func;
      req_x_coord <= x;
      req_y_coord <= y;
      req_depth   <= z;
      do @(posedge clock); while (busy !== 1'b0);
      sb.note_request(func, x, y, z);
      @(negedge clock);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < idle_pct);
      end
   endtask

   // drain responses and let a trailing draw or clear finish
   task automatic settle_block();
      start <= 1'b0;
      while (sb.pending() != 0 || busy !== 1'b0) @(negedge clock);
      repeat (4) @(negedge clock);
      while (busy !== 1'b0) @(negedge clock);
   endtask

   task automatic write_register(input logic [1:0] idx, input logic [8:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      sb.set_register(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // mostly on-screen draws and reads, with clears, spare codes and wild points
   task automatic random_phase(input logic [8:0] width_val, input logic [7:0] height_val,
                               input int count, input int pct);
      int         done_items;
      int         w;
      int         h;
      int         r;
      logic [1:0] func;
      logic [15:0] x;
      logic [15:0] y;
      logic [15:0] z;
      settle_block();
      write_register(dbas_pkg::CSR_FRAME_WIDTH, width_val);
      write_register(dbas_pkg::CSR_FRAME_HEIGHT, 9'(height_val));
      idle_pct   = pct;
      w          = sb.eff_width();
      h          = sb.eff_height();
      done_items = 0;
      while (done_items < count) begin
         r = $urandom_range(999);
         x = 16'($urandom);
         y = 16'($urandom);
         if (r < 6) begin
            func = dbas_pkg::FUNC_CLEAR;
         end else if (r < 40) begin
            func = FUNC_SPARE;
         end else if (r < 460) begin
            func = dbas_pkg::FUNC_READ;
         end else begin
            func = dbas_pkg::FUNC_DRAW;
            if ($urandom_range(9) != 0) begin
               x = 16'(int'($urandom_range(0, w + 2)) - (w / 2 + 1));
               y = 16'(int'($urandom_range(0, 2 * h + 4)) - (h + 2));
            end
         end
         case ($urandom_range(9))
            0: z = 16'h0000;
            1: z = 16'hFFFF;
            2: z = 16'($urandom_range(1, 1000));
            default: z = 16'($urandom);
         endcase
         send_request(func, x, y, z);
         if (func != FUNC_SPARE) done_items++;
      end
   endtask

   initial begin
      sb = new();
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // wait out the sweep after reset, then shrink to a 4 by 2 frame
      settle_block();
      write_register(dbas_pkg::CSR_FRAME_WIDTH, 9'd4);
      write_register(dbas_pkg::CSR_FRAME_HEIGHT, 9'd2);

      // corners, edges, depth ordering and dropped points
      send_request(dbas_pkg::FUNC_DRAW, -16'sd2, 16'sd2, 16'd1000);
      send_request(dbas_pkg::FUNC_DRAW, 16'sd2, 16'sd2, 16'd900);
      send_request(dbas_pkg::FUNC_DRAW, 16'sd0, 16'sd0, 16'd30000);
      send_request(dbas_pkg::FUNC_DRAW, 16'sd0, 16'sd0, 16'd20000);
      send_request(dbas_pkg::FUNC_DRAW, 16'sd0, 16'sd0, 16'd25000);
      send_request(dbas_pkg::FUNC_DRAW, -16'sd2, -16'sd1, 16'd0);
      send_request(dbas_pkg::FUNC_DRAW, 16'sd3, 16'sd0, 16'd500);
      send_request(dbas_pkg::FUNC_DRAW, -16'sd3, 16'sd0, 16'd500);
      send_request(dbas_pkg::FUNC_DRAW, 16'sd0, 16'sd3, 16'd500);
      send_request(dbas_pkg::FUNC_DRAW, -16'sd2, -16'sd2, 16'd500);
      send_request(dbas_pkg::FUNC_DRAW, 16'h8000, 16'h8000, 16'hFFFF);
      send_request(dbas_pkg::FUNC_DRAW, 16'h7FFF, 16'h7FFF, 16'hFFFF);
      send_request(dbas_pkg::FUNC_DRAW, -16'sd1, 16'sd1, 16'hFFFF);
      send_request(dbas_pkg::FUNC_DRAW, 16'sd0, 16'sd1, 16'd950);
      send_request(dbas_pkg::FUNC_DRAW, 16'sd1, 16'sd0, 16'd1);
      send_request(FUNC_SPARE, 16'sd0, 16'sd0, 16'd7);
      // walk the whole frame and wrap once
      repeat (9) send_request(dbas_pkg::FUNC_READ, 16'h0000, 16'hFFFF, 16'hFFFF);
      send_request(dbas_pkg::FUNC_CLEAR, 16'hFFFF, 16'h0000, 16'h0000);
      repeat (2) send_request(dbas_pkg::FUNC_READ, 16'h0000, 16'h0000, 16'h0000);

      // random traffic over a spread of frame sizes, saturated ones too
      random_phase(9'd6, 8'd4, 70, 28);
      random_phase(9'd1, 8'd1, 25, 28);
      random_phase(9'd2, 8'd3, 50, 28);
      random_phase(9'd511, 8'd255, 30, 28);
      random_phase(9'd0, 8'd0, 20, 28);
      random_phase(9'd256, 8'd1, 30, 28);
      random_phase(9'd3, 8'd128, 40, 28);
      random_phase(9'd5, 8'd2, 80, 0);
      settle_block();
      write_register(CSR_SPARE, 9'h1AA);
      random_phase(9'd80, 8'd40, 40, 28);
      random_phase(9'd7, 8'd5, 65, 28);

      // drain the expected cells, then idle before the verdict
      start <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("depth_buffer_ascii_shader test passed");
      end else begin
         $display("depth_buffer_ascii_shader test failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/dbas_pkg.sv
rtl/depth_buffer_ascii_shader.sv
verif/tb_top.sv
